// ----- rtl/rhsit_pkg.sv -----
// ============================================================================
// rhsit_pkg: shared types and constants
// Table sizes, hash constants and the request records passed between parts.
// ============================================================================
package rhsit_pkg;

  // Table geometry. The result fields are sized for these values.
  localparam int unsigned SLOTS        = 64;
  localparam int unsigned MAX_LEN      = 16;
  localparam int unsigned POOL_ENTRIES = 48;
  localparam int unsigned LenW         = $clog2(MAX_LEN + 2);

  localparam logic [31:0] HashBasis = 32'd2166136261;
  localparam logic [31:0] HashMult  = 32'd16777619;
  localparam int unsigned LoadNum   = 3;
  localparam int unsigned LoadDen   = 4;
  localparam logic [5:0]  Sat6      = 6'd63;

  // Key length, with MAX_LEN + 1 marking an over-long key, and key bytes.
  typedef logic [LenW-1:0]         key_len_t;
  typedef logic [MAX_LEN-1:0][7:0] key_bytes_t;

  // Payload of one input request.
  typedef struct packed {
    logic [7:0] key_byte;
    logic       has_byte;
    logic       last;
  } in_req_t;

  // Payload of one result.
  typedef struct packed {
    logic [5:0] string_id;
    logic       is_new;
    logic       table_full;
    logic       too_long;
    logic [5:0] probe_distance;
    logic [5:0] max_probe_seen;
  } out_rsp_t;

endpackage

// ----- rtl/rhsit_if.sv -----
// ============================================================================
// rhsit_if: valid/ready channel
// Carries one request of type T with a source and a sink side.
// ============================================================================
interface rhsit_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/rhsit_front.sv -----
// ============================================================================
// rhsit_front: byte intake
// Hashes key bytes with FNV-1a, buffers them, and hands a finished key to
// the back part through a single-entry key descriptor register.
// ============================================================================
module rhsit_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rhsit_if.sink                 in_i,
  // Key descriptor toward the back part.
  output logic                  key_valid_o,
  input  logic                  key_ready_i,
  output logic [31:0]           key_hash_o,
  output rhsit_pkg::key_len_t   key_len_o,
  output rhsit_pkg::key_bytes_t key_bytes_o
);
  import rhsit_pkg::*;

  localparam int unsigned LW = $clog2(MAX_LEN + 2);
  localparam logic [LW-1:0] MaxLen  = LW'(MAX_LEN);
  localparam logic [LW-1:0] LongLen = LW'(MAX_LEN + 1);

  logic [31:0]             hash_q, hash_d;
  logic [LW-1:0]           len_q, len_d;
  logic [MAX_LEN-1:0][7:0] buf_q, buf_d;
  logic                    full_q;
  logic [31:0]             khash_q;
  logic [LW-1:0]           klen_q;
  logic [MAX_LEN-1:0][7:0] kbuf_q;
  logic                    take;

  // One finished key may wait while the next key is being gathered.
  assign in_i.ready = !(full_q && in_i.data.last);
  assign take = in_i.valid && in_i.ready;

  always_comb begin
    hash_d = hash_q;
    len_d  = len_q;
    buf_d  = buf_q;
    if (in_i.data.has_byte) begin
      if (len_q < MaxLen) begin
        buf_d[len_q[$clog2(MAX_LEN > 1 ? MAX_LEN : 2)-1:0]] = in_i.data.key_byte;
        hash_d = (hash_q ^ {24'd0, in_i.data.key_byte}) * HashMult;
        len_d  = len_q + LW'(1);
      end else begin
        len_d = LongLen;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= HashBasis;
      len_q  <= '0;
      full_q <= 1'b0;
    end else begin
      if (key_valid_o && key_ready_i) begin
        full_q <= 1'b0;
      end
      if (take) begin
        if (in_i.data.last) begin
          hash_q <= HashBasis;
          len_q  <= '0;
          full_q <= 1'b1;
        end else begin
          hash_q <= hash_d;
          len_q  <= len_d;
        end
      end
    end
  end

  // Buffer and descriptor payload.
  always_ff @(posedge clk_i) begin
    if (take) begin
      buf_q <= buf_d;
      if (in_i.data.last) begin
        khash_q <= hash_d;
        klen_q  <= len_d;
        kbuf_q  <= buf_d;
      end
    end
  end

  assign key_valid_o = full_q;
  assign key_hash_o  = khash_q;
  assign key_len_o   = klen_q;
  assign key_bytes_o = kbuf_q;
endmodule

// ----- rtl/rhsit_back.sv -----
// ============================================================================
// rhsit_back: table engine
// Probes the slot table for a finished key, compares against the pool, and
// inserts absent keys with Robin Hood displacement.
// ============================================================================
module rhsit_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  key_valid_i,
  output logic                  key_ready_o,
  input  logic [31:0]           key_hash_i,
  input  rhsit_pkg::key_len_t   key_len_i,
  input  rhsit_pkg::key_bytes_t key_bytes_i,
  rhsit_if.source               out_o
);
  import rhsit_pkg::*;

  localparam int unsigned LW = $clog2(MAX_LEN + 2);
  localparam int unsigned SW = $clog2(SLOTS);
  localparam int unsigned IW = $clog2(POOL_ENTRIES);
  localparam int unsigned CW = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned DW = $clog2(SLOTS + 1);
  localparam int unsigned LoadLim = (SLOTS * LoadNum) / LoadDen;
  localparam logic [LW-1:0] MaxLen = LW'(MAX_LEN);

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_POOL, ST_CHECK, ST_PLACE_RD, ST_PLACE, ST_OUT
  } state_e;

  typedef struct packed {
    logic          valid;
    logic [IW-1:0] id;
    logic [DW-1:0] disp;
  } slot_t;

  // Slot table in a memory, with per-slot valid flops.
  slot_t                   slot_mem [SLOTS];
  logic [SLOTS-1:0]        slot_vld_q;
  logic [MAX_LEN*8-1:0]    pool_mem [POOL_ENTRIES];
  logic [31:0]             phash_mem [POOL_ENTRIES];
  logic [LW-1:0]           plen_mem [POOL_ENTRIES];

  state_e                  state_q;
  logic [SW-1:0]           pos_q;
  logic [DW-1:0]           d_q;
  slot_t                   rd_q;
  logic [MAX_LEN*8-1:0]    prd_q;
  logic [31:0]             phrd_q;
  logic [LW-1:0]           plrd_q;
  slot_t                   cur_q;
  logic                    placed_q;
  logic [DW-1:0]           newd_q;
  logic [CW-1:0]           cnt_q;
  logic [5:0]              maxp_q;
  out_rsp_t                rsp_q;
  logic [31:0]             khash_q;
  logic [LW-1:0]           klen_q;
  logic [MAX_LEN*8-1:0]    kbuf_q;
  logic                    match;
  logic [MAX_LEN*8-1:0]    mask;
  logic                    wr_en;
  slot_t                   wr_data;
  logic [5:0]              dsat;
  logic                    miss;
  logic                    refuse;
  logic                    pool_we;

  function automatic logic [5:0] sat(input logic [DW-1:0] v);
    sat = (v > DW'(Sat6)) ? Sat6 : 6'(v);
  endfunction

  // Bytes beyond the key length are ignored in the compare.
  always_comb begin
    for (int i = 0; i < MAX_LEN; i++) begin
      mask[i*8 +: 8] = (LW'(i) < klen_q) ? 8'hff : 8'h00;
    end
    match = rd_q.valid && (32'(rd_q.id) < POOL_ENTRIES) && phrd_q == khash_q &&
            plrd_q == klen_q && ((prd_q & mask) == (kbuf_q & mask));
  end

  assign key_ready_o = (state_q == ST_IDLE);
  assign out_o.valid = (state_q == ST_OUT);
  assign out_o.data  = rsp_q;
  assign dsat = sat(cur_q.disp + DW'(1));

  // A probe ends without a hit at an empty slot or after a full lap.
  assign miss    = !rd_q.valid || (d_q == DW'(SLOTS));
  assign refuse  = (32'(cnt_q) >= LoadLim) || (32'(cnt_q) >= POOL_ENTRIES);
  assign pool_we = (state_q == ST_CHECK) && miss && !refuse;

  // Slot and pool reads, registered; slot and pool writes.
  always_ff @(posedge clk_i) begin
    rd_q   <= '{valid: slot_vld_q[pos_q], id: slot_mem[pos_q].id,
                disp: slot_mem[pos_q].disp};
    prd_q  <= pool_mem[rd_q.id];
    phrd_q <= phash_mem[rd_q.id];
    plrd_q <= plen_mem[rd_q.id];
    if (wr_en) begin
      slot_mem[pos_q] <= wr_data;
    end
    if (pool_we) begin
      pool_mem[cnt_q[IW-1:0]]  <= kbuf_q;
      phash_mem[cnt_q[IW-1:0]] <= khash_q;
      plen_mem[cnt_q[IW-1:0]]  <= klen_q;
    end
  end

  // Slot write during placement: an empty slot or a richer resident.
  always_comb begin
    wr_en   = 1'b0;
    wr_data = cur_q;
    if (state_q == ST_PLACE) begin
      if (!rd_q.valid || rd_q.disp < cur_q.disp) begin
        wr_en = 1'b1;
      end
    end
  end

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      slot_vld_q <= '0;
      cnt_q      <= '0;
      maxp_q     <= '0;
      pos_q      <= '0;
      d_q        <= '0;
      cur_q      <= '0;
      placed_q   <= 1'b0;
      newd_q     <= '0;
      rsp_q      <= '0;
      khash_q    <= '0;
      klen_q     <= '0;
      kbuf_q     <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (key_valid_i) begin
            khash_q <= key_hash_i;
            klen_q  <= key_len_i;
            kbuf_q  <= key_bytes_i;
            pos_q   <= key_hash_i[SW-1:0];
            d_q     <= '0;
            if (key_len_i > MaxLen) begin
              rsp_q   <= '{string_id: '0, is_new: 1'b0, table_full: 1'b0,
                           too_long: 1'b1, probe_distance: '0,
                           max_probe_seen: maxp_q};
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_READ;
            end
          end
        end
        // Wait for slot read, then for pool read.
        ST_READ: state_q <= ST_POOL;
        ST_POOL: state_q <= ST_CHECK;
        ST_CHECK: begin
          if (miss) begin
            if (refuse) begin
              rsp_q   <= '{string_id: '0, is_new: 1'b0, table_full: 1'b1,
                           too_long: 1'b0, probe_distance: '0,
                           max_probe_seen: maxp_q};
              state_q <= ST_OUT;
            end else begin
              cur_q    <= '{valid: 1'b1, id: cnt_q[IW-1:0], disp: '0};
              placed_q <= 1'b0;
              newd_q   <= '0;
              pos_q    <= khash_q[SW-1:0];
              state_q  <= ST_PLACE_RD;
            end
          end else if (match) begin
            rsp_q   <= '{string_id: 6'(rd_q.id), is_new: 1'b0, table_full: 1'b0,
                         too_long: 1'b0, probe_distance: sat(d_q),
                         max_probe_seen: maxp_q};
            state_q <= ST_OUT;
          end else begin
            pos_q   <= pos_q + SW'(1);
            d_q     <= d_q + DW'(1);
            state_q <= ST_READ;
          end
        end
        // Slot read for the next displacement step.
        ST_PLACE_RD: state_q <= ST_PLACE;
        // One displacement step per slot.
        ST_PLACE: begin
          if (!rd_q.valid) begin
            slot_vld_q[pos_q] <= 1'b1;
            cnt_q             <= cnt_q + CW'(1);
            rsp_q   <= '{string_id: 6'(cnt_q), is_new: 1'b1, table_full: 1'b0,
                         too_long: 1'b0,
                         probe_distance: sat(placed_q ? newd_q : cur_q.disp),
                         max_probe_seen: maxp_q};
            state_q <= ST_OUT;
          end else begin
            if (rd_q.disp < cur_q.disp) begin
              cur_q <= '{valid: 1'b1, id: rd_q.id, disp: rd_q.disp + DW'(1)};
              if (!placed_q) begin
                placed_q <= 1'b1;
                newd_q   <= cur_q.disp;
              end
              if (sat(rd_q.disp + DW'(1)) > maxp_q) maxp_q <= sat(rd_q.disp + DW'(1));
            end else begin
              cur_q.disp <= cur_q.disp + DW'(1);
              if (dsat > maxp_q) maxp_q <= dsat;
            end
            pos_q   <= pos_q + SW'(1);
            state_q <= ST_PLACE_RD;
          end
        end
        ST_OUT: begin
          if (out_o.ready) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/robin_hood_string_intern_table.sv -----
// Interns key strings: bytes enter one per cycle while the intake is ready
// and are hashed at once; a final request sets a registered descriptor for
// the back engine in the cycle after it is taken. The probe walk visits each
// slot by slot read, pool read and compare; new keys then take a Robin Hood
// placement pass of slot read and displacement step per slot. The result is
// then held until taken. The next key may be gathered while the previous one
// is probed; its final request waits until the back engine has taken the previous key.
// ============================================================================
// robin_hood_string_intern_table: top level
// Connects the byte front end to the table back end.
// ============================================================================
module robin_hood_string_intern_table (
  input  logic    clk_i,
  input  logic    rst_ni,
  rhsit_if.sink   in_i,
  rhsit_if.source out_o
);
  import rhsit_pkg::*;

  logic       key_valid;
  logic       key_ready;
  logic [31:0] key_hash;
  key_len_t   key_len;
  key_bytes_t key_bytes;

  rhsit_front u_front (
    .clk_i, .rst_ni, .in_i,
    .key_valid_o(key_valid), .key_ready_i(key_ready),
    .key_hash_o(key_hash), .key_len_o(key_len), .key_bytes_o(key_bytes)
  );

  rhsit_back u_back (
    .clk_i, .rst_ni,
    .key_valid_i(key_valid), .key_ready_o(key_ready),
    .key_hash_i(key_hash), .key_len_i(key_len), .key_bytes_i(key_bytes),
    .out_o
  );
endmodule

// ----- rtl/rhsit_checks.sv -----
// ============================================================================
// rhsit_checks: port checker
// Watches the result port of the intern table.
// ============================================================================
module rhsit_checks (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input rhsit_pkg::out_rsp_t  out_data_i
);
  import rhsit_pkg::*;

  // A held result does not change.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i)) else $error("hold");

  // At most one outcome flag is set.
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $onehot0({out_data_i.is_new, out_data_i.table_full,
                              out_data_i.too_long})) else $error("flags");

  // Refused keys report no id.
  a_refuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.table_full || out_data_i.too_long) |->
      out_data_i.string_id == '0 && out_data_i.probe_distance == '0) else $error("refuse");

  // Distance never exceeds the maximum seen.
  a_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.probe_distance <= out_data_i.max_probe_seen)
    else $error("max");
endmodule

bind robin_hood_string_intern_table rhsit_checks u_checks (
  .clk_i(clk_i), .rst_ni(rst_ni), .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready), .out_data_i(out_o.data)
);

// ----- bench/tb.sv -----
// ============================================================================
// tb: regression bench for robin_hood_string_intern_table
// Streams key strings byte by byte, predicts each lookup or insert result
// with a behavioral copy of the intern table, and checks every result.
// ============================================================================
`timescale 1ns / 1ps

module tb;
  import rhsit_pkg::*;

  localparam int unsigned LoadLimit    = (SLOTS * LoadNum) / LoadDen;
  localparam int          WatchLimit   = 20000;

  logic clk_i;
  logic rst_ni;

  rhsit_if #(.T(in_req_t))  in_ch ();
  rhsit_if #(.T(out_rsp_t)) out_ch ();

  robin_hood_string_intern_table uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  // Predictor state: a behavioral copy of the table.
  typedef struct {
    bit       valid;
    bit [5:0] id;
    int       disp;
  } slot_entry_t;

  slot_entry_t slot_mem [SLOTS];
  bit [7:0]    pool_mem [POOL_ENTRIES][MAX_LEN];
  bit [31:0]   pool_hash [POOL_ENTRIES];
  int          pool_len [POOL_ENTRIES];
  bit [7:0]    key_buf [MAX_LEN];
  bit [31:0]   cur_hash;
  int          cur_len;
  int          n_stored;
  int          max_dist;

  in_req_t  pending_reqs [$];
  out_rsp_t expected_rsps [$];
  int       n_errors;
  bit       stim_done;
  bit       hold_off;
  bit       in_fire;

  // Strings reused so lookups hit existing entries.
  typedef bit [7:0] key_t [$];
  key_t known_keys [$];

  function automatic int sat6(int v);
    return (v > 63) ? 63 : v;
  endfunction

  function automatic void note_dist(int d);
    if (d > max_dist) max_dist = sat6(d);
  endfunction

  // Robin Hood insert; returns the distance of the new key's own slot.
  function automatic int place_key(bit [5:0] id, bit [31:0] h);
    slot_entry_t carried, tmp;
    int pos, newdist;
    bit placed;
    pos = int'(h % SLOTS);
    newdist = 0;
    placed = 0;
    carried.valid = 1;
    carried.id = id;
    carried.disp = 0;
    for (int n = 0; n < SLOTS; n++) begin
      if (!slot_mem[pos].valid) begin
        if (!placed) newdist = carried.disp;
        slot_mem[pos] = carried;
        return newdist;
      end
      if (slot_mem[pos].disp < carried.disp) begin
        tmp = slot_mem[pos];
        slot_mem[pos] = carried;
        carried = tmp;
        if (!placed) begin
          newdist = slot_mem[pos].disp;
          placed = 1;
        end
      end
      carried.disp++;
      note_dist(carried.disp);
      pos = (pos + 1) % SLOTS;
    end
    return newdist;
  endfunction

  // Folds one accepted request into the model; a final byte yields a result.
  function automatic void intern_step(in_req_t r);
    out_rsp_t rsp;
    int pos, hit_id, hit_dist;
    bit found, same;
    rsp = '0;
    found = 0;
    hit_id = 0;
    hit_dist = 0;
    if (r.has_byte) begin
      if (cur_len < MAX_LEN) begin
        key_buf[cur_len] = r.key_byte;
        cur_hash = (cur_hash ^ {24'd0, r.key_byte}) * HashMult;
        cur_len++;
      end else begin
        cur_len = MAX_LEN + 1;
      end
    end
    if (!r.last) return;
    if (cur_len > MAX_LEN) begin
      rsp.too_long = 1;
    end else begin
      pos = int'(cur_hash % SLOTS);
      for (int d = 0; d < SLOTS; d++) begin
        if (!slot_mem[pos].valid) break;
        hit_id = int'(slot_mem[pos].id);
        same = (pool_hash[hit_id] == cur_hash) && (pool_len[hit_id] == cur_len);
        for (int i = 0; i < cur_len; i++)
          if (pool_mem[hit_id][i] != key_buf[i]) same = 0;
        if (same) begin
          found = 1;
          hit_dist = d;
          break;
        end
        pos = (pos + 1) % SLOTS;
      end
      if (found) begin
        rsp.string_id = 6'(hit_id);
        rsp.probe_distance = 6'(sat6(hit_dist));
      end else if (n_stored >= LoadLimit || n_stored >= POOL_ENTRIES) begin
        rsp.table_full = 1;
      end else begin
        for (int i = 0; i < cur_len; i++) pool_mem[n_stored][i] = key_buf[i];
        pool_hash[n_stored] = cur_hash;
        pool_len[n_stored] = cur_len;
        rsp.string_id = 6'(n_stored);
        rsp.probe_distance = 6'(sat6(place_key(6'(n_stored), cur_hash)));
        rsp.is_new = 1;
        n_stored++;
      end
    end
    rsp.max_probe_seen = 6'(max_dist);
    expected_rsps.push_back(rsp);
    cur_hash = HashBasis;
    cur_len = 0;
  endfunction

  // Queues one key string; optional filler requests are mixed in.
  task automatic push_key(key_t k, bit fillers);
    in_req_t r;
    for (int i = 0; i < k.size(); i++) begin
      if (fillers && $urandom_range(0, 7) == 0) begin
        r.key_byte = 8'($urandom);
        r.has_byte = 0;
        r.last = 0;
        pending_reqs.push_back(r);
      end
      r.key_byte = k[i];
      r.has_byte = 1;
      r.last = (i == k.size() - 1) && !(fillers && $urandom_range(0, 3) == 0);
      pending_reqs.push_back(r);
    end
    if (k.size() == 0 || !r.last) begin
      r.key_byte = 8'($urandom);
      r.has_byte = 0;
      r.last = 1;
      pending_reqs.push_back(r);
    end
  endtask

  function automatic key_t rand_key(int len);
    key_t k;
    for (int i = 0; i < len; i++) k.push_back(8'($urandom_range(0, 255)));
    return k;
  endfunction

  // Clock and reset.
  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
  end

  // Stimulus: directed keys first, then mostly repeated and fresh keys.
  initial begin
    key_t k;
    key_t empty_key;
    int choice;
    cur_hash = HashBasis;
    cur_len = 0;
    n_stored = 0;
    max_dist = 0;
    n_errors = 0;
    for (int s = 0; s < SLOTS; s++) slot_mem[s] = '{0, 0, 0};
    k = {8'h00};
    push_key(k, 0);
    k = {8'hff};
    push_key(k, 0);
    push_key(empty_key, 0);
    push_key(empty_key, 0);
    k = {8'h00};
    push_key(k, 0);
    k = {8'h55, 8'haa};
    push_key(k, 1);
    k = rand_key(MAX_LEN);
    push_key(k, 0);
    push_key(k, 0);
    k = rand_key(MAX_LEN + 1);
    push_key(k, 0);
    while (pending_reqs.size() < 1000) begin
      choice = $urandom_range(0, 9);
      if (choice < 4 && known_keys.size() > 0) begin
        k = known_keys[$urandom_range(0, known_keys.size() - 1)];
      end else if (choice == 9) begin
        k = rand_key($urandom_range(MAX_LEN + 1, MAX_LEN + 6));
      end else begin
        k = rand_key($urandom_range(0, $urandom_range(0, 1) ? 4 : MAX_LEN));
        if (known_keys.size() < 80) known_keys.push_back(k);
      end
      push_key(k, $urandom_range(0, 1));
    end
  end

  // Request handshake, sampled at the rising edge where it takes place.
  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_ch.valid && in_ch.ready;
  end

  // Driver: bursts of requests with random gaps, changed at the falling edge.
  int burst_left;
  int gap_left;
  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    burst_left = 0;
    gap_left = 0;
    stim_done = 0;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) begin
        intern_step(in_ch.data);
        void'(pending_reqs.pop_front());
      end
      if (!in_ch.valid || in_fire) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 0;
        end else if (pending_reqs.size() > 0) begin
          in_ch.valid <= 1;
          in_ch.data <= pending_reqs[0];
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
          end else begin
            burst_left--;
            if (burst_left == 0) gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_ch.valid <= 0;
          stim_done <= 1;
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off early in the run.
  int rx_cycles;
  initial begin
    out_ch.ready = 0;
    rx_cycles = 0;
    hold_off = 0;
  end

  always @(negedge clk_i) begin
    rx_cycles <= rx_cycles + 1;
    hold_off <= (rx_cycles >= 200 && rx_cycles < 600);
    if (hold_off) out_ch.ready <= 0;
    else if (rx_cycles % 512 < 256) out_ch.ready <= 1;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  // Monitor: compares each result with the oldest expectation.
  always @(posedge clk_i) begin
    out_rsp_t exp_rsp;
    out_rsp_t got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_rsps.size() == 0) begin
        $error("unexpected result: string_id %0d", got.string_id);
        n_errors++;
      end else begin
        exp_rsp = expected_rsps.pop_front();
        if (got.string_id !== exp_rsp.string_id) begin
          $error("string_id: expected %0d, got %0d", exp_rsp.string_id, got.string_id);
          n_errors++;
        end
        if (got.is_new !== exp_rsp.is_new) begin
          $error("is_new: expected %0d, got %0d", exp_rsp.is_new, got.is_new);
          n_errors++;
        end
        if (got.table_full !== exp_rsp.table_full) begin
          $error("table_full: expected %0d, got %0d", exp_rsp.table_full,
                 got.table_full);
          n_errors++;
        end
        if (got.too_long !== exp_rsp.too_long) begin
          $error("too_long: expected %0d, got %0d", exp_rsp.too_long, got.too_long);
          n_errors++;
        end
        if (got.probe_distance !== exp_rsp.probe_distance) begin
          $error("probe_distance: expected %0d, got %0d", exp_rsp.probe_distance,
                 got.probe_distance);
          n_errors++;
        end
        if (got.max_probe_seen !== exp_rsp.max_probe_seen) begin
          $error("max_probe_seen: expected %0d, got %0d", exp_rsp.max_probe_seen,
                 got.max_probe_seen);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles without any accepted request or result.
  int idle_cycles;
  initial idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("robin_hood_string_intern_table regression: fail");
      $finish;
    end
  end

  // End of run: drain expectations, then let trailing results show up.
  initial begin
    wait (stim_done);
    wait (expected_rsps.size() == 0);
    repeat (600) @(posedge clk_i);
    if (n_errors == 0 && expected_rsps.size() == 0) begin
      $display("robin_hood_string_intern_table regression: pass");
    end else begin
      $display("robin_hood_string_intern_table regression: fail");
    end
    $finish;
  end

endmodule
